@@ design/ttdg_pkg.sv @@
// Shared types and constants for the depth-preferred transposition table.
`timescale 1ns / 1ps

package ttdg_pkg;

    // Default number of index bits, which sets the table depth.
    localparam int INDEX_BITS_DEF = 16;

    // Width of the table_log2 register and its reset value.
    localparam int LOG2_W     = 5;
    localparam int LOG2_RESET = 16;

    // The fill estimate samples at most this many leading entries.
    localparam int SAMPLE_MAX  = 1000;
    localparam int SAMPLE_LOG2 = 10;
    localparam int COUNT_W     = 10;

    // Configuration register map (byte address bit 2 selects the register).
    localparam int PADDR_W = 3;
    localparam logic ADDR_TABLE_LOG2 = 1'b0;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_PROBE  = 2'd0,
        CMD_STORE  = 2'd1,
        CMD_NEWGEN = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_CLEAR
    } state_t;

    // One table entry: key plus stored payload.
    typedef struct packed {
        logic [31:0]        key;
        logic [7:0]         gen;
        logic [1:0]         flag;
        logic [7:0]         depth;
        logic [7:0]         to_sq;
        logic [7:0]         from_sq;
        logic signed [15:0] score;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture an accepted word and read its entry
        logic access;      // update cycle of an accepted word
        logic clear_step;  // write one empty entry of the clearing pass
        logic cfg_wr;      // table_log2 write, restarts the clearing pass
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cmd_clear;   // captured word is a clear command
        logic clear_last;  // clearing pass is at its last entry
    } stat_t;

endpackage

@@ design/ttdg_ctrl.sv @@
// Controller state machine for the transposition table.
`timescale 1ns / 1ps

module ttdg_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ttdg_pkg::PADDR_W-1:0]  paddr,
    input  ttdg_pkg::stat_t               stat,
    output ttdg_pkg::ctrl_t               ctrl,
    output logic                          busy,
    output logic                          done
);
    import ttdg_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   reply_reg;
    logic   reply_next;
    logic   done_reg;
    logic   done_next;
    logic   cfg_wr;
    logic   accept;

    // Decode a completed write to the table_log2 register.
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_TABLE_LOG2);
    assign busy   = (state_reg != ST_IDLE) || cfg_wr;
    assign accept = start && !busy;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        if (cfg_wr)
        begin
            state_next = ST_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_next = ST_ACCESS;
                    end
                end
                ST_ACCESS:
                begin
                    state_next = stat.cmd_clear ? ST_CLEAR : ST_IDLE;
                end
                ST_CLEAR:
                begin
                    if (stat.clear_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // Outputs toward the datapath and the result strobe.
    always_comb
    begin
        ctrl.load       = accept;
        ctrl.access     = 1'b0;
        ctrl.clear_step = 1'b0;
        ctrl.cfg_wr     = cfg_wr;
        reply_next      = reply_reg;
        done_next       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                reply_next = 1'b0;
            end
            ST_ACCESS:
            begin
                ctrl.access = 1'b1;
                reply_next  = stat.cmd_clear;
                done_next   = !stat.cmd_clear;
            end
            ST_CLEAR:
            begin
                ctrl.clear_step = 1'b1;
                if (stat.clear_last && !cfg_wr)
                begin
                    done_next  = reply_reg;
                    reply_next = 1'b0;
                end
            end
            default:
            begin
                reply_next = 1'b0;
            end
        endcase
    end

    // State registers; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            reply_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;

    // An accepted word always moves on to its update cycle.
    a_accept_access: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_ACCESS))
        else $error("accepted word did not reach the update cycle");

    // A result only follows an update cycle or the end of a clearing pass.
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_ACCESS || $past(state_reg) == ST_CLEAR))
        else $error("result strobe without a finished word");

    // Every command other than clear answers right after its update cycle.
    a_access_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCESS && !stat.cmd_clear && !cfg_wr) |=> done_reg)
        else $error("update cycle gave no result");

endmodule

@@ design/ttdg_dpath.sv @@
// Datapath of the transposition table: entry memory, counters and result registers.
`timescale 1ns / 1ps

module ttdg_dpath
#(
    parameter int INDEX_BITS = ttdg_pkg::INDEX_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ttdg_pkg::ctrl_t              ctrl,
    output ttdg_pkg::stat_t              stat,
    input  logic [31:0]                  pwdata,
    output logic [ttdg_pkg::LOG2_W-1:0]  log2_out,
    input  logic [1:0]                   command,
    input  logic [63:0]                  hash,
    input  logic signed [15:0]           score_in,
    input  logic [7:0]                   from_in,
    input  logic [7:0]                   move_to,
    input  logic [7:0]                   depth_in,
    input  logic [1:0]                   flag_in,
    output logic                         hit,
    output logic signed [15:0]           score_out,
    output logic [7:0]                   from_out,
    output logic [7:0]                   to_out,
    output logic [7:0]                   depth_out,
    output logic [1:0]                   flag_out,
    output logic [7:0]                   gen_out,
    output logic [9:0]                   fill_permille
);
    import ttdg_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;
    localparam int CMP_W = (INDEX_BITS > SAMPLE_LOG2) ? INDEX_BITS : SAMPLE_LOG2;
    localparam int PROD_W = COUNT_W + SAMPLE_LOG2;
    localparam logic [LOG2_W-1:0] LOG2_INIT =
        (LOG2_RESET > INDEX_BITS) ? LOG2_W'(INDEX_BITS) : LOG2_W'(LOG2_RESET);

    entry_t                  entry_mem [DEPTH];
    entry_t                  rd_reg;
    entry_t                  res_reg;
    logic                    hit_reg;
    cmd_t                    cmd_reg;
    logic [31:0]             key_reg;
    logic [INDEX_BITS-1:0]   idx_reg;
    logic                    in_sample_reg;
    logic signed [15:0]      score_reg;
    logic [7:0]              from_reg;
    logic [7:0]              to_reg;
    logic [7:0]              depth_reg;
    logic [1:0]              flag_reg;
    logic [7:0]              gen_reg;
    logic [7:0]              gen_next;
    logic [COUNT_W-1:0]      count_reg;
    logic [COUNT_W-1:0]      count_next;
    logic [LOG2_W-1:0]       log2_reg;
    logic [LOG2_W-1:0]       log2_next;
    logic [INDEX_BITS-1:0]   clr_cnt_reg;
    logic [INDEX_BITS-1:0]   clr_cnt_next;

    logic [INDEX_BITS-1:0]   idx_mask;
    logic [INDEX_BITS-1:0]   idx_in;
    logic                    keep;
    logic                    match;
    logic                    store_wr;
    logic                    mem_we;
    logic [INDEX_BITS-1:0]   mem_waddr;
    entry_t                  mem_wdata;
    entry_t                  new_entry;
    logic [PROD_W-1:0]       fill_prod;

    // Index of an incoming word under the current table size.
    assign idx_mask = ~({INDEX_BITS{1'b1}} << log2_reg);
    assign idx_in   = hash[INDEX_BITS-1:0] & idx_mask;

    // Capture the accepted word.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg       <= cmd_t'(command);
            key_reg       <= hash[63:32];
            idx_reg       <= idx_in;
            in_sample_reg <= CMP_W'(idx_in) < CMP_W'(SAMPLE_MAX);
            score_reg     <= score_in;
            from_reg      <= from_in;
            to_reg        <= move_to;
            depth_reg     <= depth_in;
            flag_reg      <= flag_in;
        end
    end

    // Replacement decision and the entry a store would write.
    always_comb
    begin
        match = (rd_reg.key != 32'd0) && (rd_reg.key == key_reg);
        keep  = match && (rd_reg.gen == gen_reg) && (rd_reg.depth > depth_reg);
        store_wr = ctrl.access && (cmd_reg == CMD_STORE) && !keep;
        new_entry.key     = key_reg;
        new_entry.gen     = gen_reg;
        new_entry.flag    = flag_reg;
        new_entry.depth   = depth_reg;
        new_entry.to_sq   = to_reg;
        new_entry.from_sq = from_reg;
        new_entry.score   = score_reg;
        mem_we    = store_wr || ctrl.clear_step;
        mem_waddr = ctrl.clear_step ? clr_cnt_reg : idx_reg;
        mem_wdata = ctrl.clear_step ? '0 : new_entry;
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (ctrl.load)
        begin
            rd_reg <= entry_mem[idx_in];
        end
    end

    // Next values of generation, fill count, size register and clear counter.
    always_comb
    begin
        gen_next     = gen_reg;
        count_next   = count_reg;
        log2_next    = log2_reg;
        clr_cnt_next = clr_cnt_reg;
        if (ctrl.cfg_wr)
        begin
            log2_next    = (pwdata[LOG2_W-1:0] > LOG2_W'(INDEX_BITS)) ?
                           LOG2_W'(INDEX_BITS) : pwdata[LOG2_W-1:0];
            count_next   = '0;
            clr_cnt_next = '0;
        end
        else
        begin
            if (ctrl.clear_step)
            begin
                clr_cnt_next = clr_cnt_reg + INDEX_BITS'(1);
            end
            if (ctrl.access)
            begin
                case (cmd_reg)
                    CMD_STORE:
                    begin
                        if (store_wr && in_sample_reg)
                        begin
                            if (rd_reg.key == 32'd0 && key_reg != 32'd0)
                            begin
                                count_next = count_reg + COUNT_W'(1);
                            end
                            else if (rd_reg.key != 32'd0 && key_reg == 32'd0)
                            begin
                                count_next = count_reg - COUNT_W'(1);
                            end
                        end
                    end
                    CMD_NEWGEN:
                    begin
                        gen_next = gen_reg + 8'd1;
                    end
                    CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg     <= '0;
            count_reg   <= '0;
            log2_reg    <= LOG2_INIT;
            clr_cnt_reg <= '0;
        end
        else
        begin
            gen_reg     <= gen_next;
            count_reg   <= count_next;
            log2_reg    <= log2_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Result registers: payload only on a probe hit.
    always_ff @(posedge clk)
    begin
        if (ctrl.access)
        begin
            hit_reg <= (cmd_reg == CMD_PROBE) && match;
            res_reg <= ((cmd_reg == CMD_PROBE) && match) ? rd_reg : '0;
        end
    end

    // Fill estimate: count scaled by 1000 over the sample size.
    assign fill_prod = PROD_W'(count_reg) * PROD_W'(SAMPLE_MAX);
    assign fill_permille = (log2_reg >= LOG2_W'(SAMPLE_LOG2)) ? count_reg :
                           COUNT_W'(fill_prod >> log2_reg);

    assign stat.cmd_clear  = (cmd_reg == CMD_CLEAR);
    assign stat.clear_last = (clr_cnt_reg == {INDEX_BITS{1'b1}});
    assign log2_out  = log2_reg;
    assign hit       = hit_reg;
    assign score_out = res_reg.score;
    assign from_out  = res_reg.from_sq;
    assign to_out    = res_reg.to_sq;
    assign depth_out = res_reg.depth;
    assign flag_out  = res_reg.flag;
    assign gen_out   = res_reg.gen;

    // The running count never exceeds the sample size.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(SAMPLE_MAX))
        else $error("fill count beyond sample size");

    // The size register never exceeds the index width.
    a_log2_range: assert property (@(posedge clk) disable iff (!rst_n)
        log2_reg <= LOG2_W'(INDEX_BITS))
        else $error("table size beyond index width");

endmodule

@@ design/transposition_table_depth_gen.sv @@
// Top level of the depth-preferred transposition table.
`timescale 1ns / 1ps

// Direct-mapped transposition table with 2**INDEX_BITS entries. A command word
// is taken when start is high and busy is low. Probe, store and new-search
// commands have two steps: the registered read of the entry memory, then the
// compare, replace decision and write-back; done pulses for one cycle in the
// cycle after, and the next word can be taken in that same cycle. A clear
// command walks the entry memory one entry per cycle, then pulses done. After
// reset, and after every write of table_log2, the same clearing pass runs with
// busy high and no result word. The receiver cannot stall: the result ports are
// valid only in the cycle in which done is high.
module transposition_table_depth_gen
#(
    parameter int INDEX_BITS = ttdg_pkg::INDEX_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    command,
    input  logic [63:0]                   hash,
    input  logic signed [15:0]            score_in,
    input  logic [7:0]                    from_in,
    input  logic [7:0]                    move_to,
    input  logic [7:0]                    depth_in,
    input  logic [1:0]                    flag_in,
    output logic                          done,
    output logic                          hit,
    output logic signed [15:0]            score_out,
    output logic [7:0]                    from_out,
    output logic [7:0]                    to_out,
    output logic [7:0]                    depth_out,
    output logic [1:0]                    flag_out,
    output logic [7:0]                    gen_out,
    output logic [9:0]                    fill_permille,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ttdg_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ttdg_pkg::*;

    ctrl_t              ctrl;
    stat_t              stat;
    logic [LOG2_W-1:0]  log2_val;

    ttdg_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .stat    (stat),
        .ctrl    (ctrl),
        .busy    (busy),
        .done    (done)
    );

    ttdg_dpath #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .pwdata        (pwdata),
        .log2_out      (log2_val),
        .command       (command),
        .hash          (hash),
        .score_in      (score_in),
        .from_in       (from_in),
        .move_to       (move_to),
        .depth_in      (depth_in),
        .flag_in       (flag_in),
        .hit           (hit),
        .score_out     (score_out),
        .from_out      (from_out),
        .to_out        (to_out),
        .depth_out     (depth_out),
        .flag_out      (flag_out),
        .gen_out       (gen_out),
        .fill_permille (fill_permille)
    );

    // Register read-back; addresses past the register map read as zero.
    assign prdata = (paddr[2] == ADDR_TABLE_LOG2) ? {{(32 - LOG2_W){1'b0}}, log2_val} : 32'd0;
    assign pready = 1'b1;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the depth-preferred transposition table.
`timescale 1ns / 1ps

module tb_top;

    import ttdg_pkg::*;

    localparam int TT_DEPTH = 1 << INDEX_BITS_DEF;

    // Byte addresses of the table_log2 register and of an unmapped slot.
    localparam logic [PADDR_W-1:0] TL2_ADDR   = {ADDR_TABLE_LOG2, 2'b00};
    localparam logic [PADDR_W-1:0] SPARE_ADDR = {~ADDR_TABLE_LOG2, 2'b00};

    // One command word as the sender sees it.
    typedef struct packed {
        cmd_t               command;
        logic [63:0]        hash;
        logic signed [15:0] score;
        logic [7:0]         from_sq;
        logic [7:0]         to_sq;
        logic [7:0]         depth;
        logic [1:0]         flag;
    } tt_word_t;

    // One result word as the table should return it.
    typedef struct packed {
        cmd_t               cmd;
        logic               hit;
        logic signed [15:0] score;
        logic [7:0]         from_sq;
        logic [7:0]         to_sq;
        logic [7:0]         depth;
        logic [1:0]         flag;
        logic [7:0]         gen;
        logic [9:0]         fill;
    } tt_reply_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [1:0]                 command = '0;
    logic [63:0]                hash = '0;
    logic signed [15:0]         score_in = '0;
    logic [7:0]                 from_in = '0;
    logic [7:0]                 move_to = '0;
    logic [7:0]                 depth_in = '0;
    logic [1:0]                 flag_in = '0;
    logic                       done;
    logic                       hit;
    logic signed [15:0]         score_out;
    logic [7:0]                 from_out;
    logic [7:0]                 to_out;
    logic [7:0]                 depth_out;
    logic [1:0]                 flag_out;
    logic [7:0]                 gen_out;
    logic [9:0]                 fill_permille;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PADDR_W-1:0]         paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;

    // Shadow copy of the table, generation, fill count and table size.
    entry_t                     shadow_entries [0:TT_DEPTH-1];
    logic [7:0]                 shadow_gen;
    int unsigned                shadow_filled;
    int unsigned                shadow_log2;

    tt_word_t                   command_word_q [$];
    tt_reply_t                  table_reply_q [$];
    tt_word_t                   cur_word;
    tt_reply_t                  want;
    int                         burst_left = 1;
    int                         gap_left = 0;
    int                         mismatch_count = 0;
    int                         clears_left = 2;
    logic [31:0]                key_pool [8];
    logic [31:0]                idx_pool [12];
    int                         log2_plan [5] = '{0, 3, 9, 10, 31};

    transposition_table_depth_gen u_top (.*);

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Empty every entry and drop the fill count.
    function automatic void table_wipe();
        foreach (shadow_entries[i])
        begin
            shadow_entries[i] = '0;
        end
        shadow_filled = 0;
    endfunction

    // Apply one command word to the shadow table and return the reply it earns.
    function automatic tt_reply_t table_apply(tt_word_t w);
        tt_reply_t   r;
        entry_t      ent;
        logic [31:0] mask;
        int unsigned idx;
        int unsigned sample;
        logic [31:0] key;
        r = '0;
        r.cmd = w.command;
        mask = (32'd1 << shadow_log2) - 32'd1;
        idx = (w.hash[31:0] & mask) & (TT_DEPTH - 1);
        key = w.hash[63:32];
        ent = shadow_entries[idx];
        sample = (shadow_log2 >= SAMPLE_LOG2) ? SAMPLE_MAX : (1 << shadow_log2);
        case (w.command)
            CMD_PROBE:
            begin
                if (ent.key != 0 && ent.key == key)
                begin
                    r.hit = 1'b1;
                    r.score = ent.score;
                    r.from_sq = ent.from_sq;
                    r.to_sq = ent.to_sq;
                    r.depth = ent.depth;
                    r.flag = ent.flag;
                    r.gen = ent.gen;
                end
            end
            CMD_STORE:
            begin
                // A deeper entry of the same position from this search survives.
                if (!(ent.key != 0 && ent.key == key && ent.gen == shadow_gen
                      && ent.depth > w.depth))
                begin
                    if (idx < sample)
                    begin
                        if (ent.key == 0 && key != 0)
                            shadow_filled++;
                        else if (ent.key != 0 && key == 0)
                            shadow_filled--;
                    end
                    ent.key = key;
                    ent.gen = shadow_gen;
                    ent.flag = w.flag;
                    ent.depth = w.depth;
                    ent.to_sq = w.to_sq;
                    ent.from_sq = w.from_sq;
                    ent.score = w.score;
                    shadow_entries[idx] = ent;
                end
            end
            CMD_NEWGEN:
            begin
                shadow_gen = shadow_gen + 8'd1;
            end
            CMD_CLEAR:
            begin
                table_wipe();
            end
        endcase
        r.fill = 10'((shadow_filled * SAMPLE_MAX) / sample);
        return r;
    endfunction

    // A register write; only table_log2 exists, and writing it clears the table.
    function automatic void table_config(logic [PADDR_W-1:0] addr, logic [31:0] data);
        if (addr == TL2_ADDR)
        begin
            shadow_log2 = (data[4:0] > INDEX_BITS_DEF) ? INDEX_BITS_DEF : data[4:0];
            table_wipe();
        end
    endfunction

    function automatic void push_word(cmd_t c, logic [63:0] h, logic [15:0] s,
                                      logic [7:0] fr, logic [7:0] tq,
                                      logic [7:0] d, logic [1:0] f);
        tt_word_t w;
        w.command = c;
        w.hash = h;
        w.score = s;
        w.from_sq = fr;
        w.to_sq = tq;
        w.depth = d;
        w.flag = f;
        command_word_q.push_back(w);
    endfunction

    // New keys and favored slots for a phase, so that probes and stores collide.
    function automatic void refill_pools();
        key_pool[0] = '0;
        for (int i = 1; i < 8; i++)
        begin
            key_pool[i] = $urandom;
        end
        for (int i = 0; i < 12; i++)
        begin
            if (i < 6)
                idx_pool[i] = $urandom_range(0, SAMPLE_MAX - 1);
            else if (i < 10)
                idx_pool[i] = $urandom_range(SAMPLE_MAX, TT_DEPTH - 1);
            else
                idx_pool[i] = $urandom_range(SAMPLE_MAX - 10, SAMPLE_MAX + 10);
        end
    endfunction

    // Random words, mostly on pooled keys and slots; a few fully random keys.
    function automatic void push_random(int count);
        int unsigned roll;
        logic [31:0] mask;
        logic [31:0] idx;
        logic [31:0] key;
        cmd_t        c;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
                c = CMD_PROBE;
            else if (roll < 88)
                c = CMD_STORE;
            else if (roll < 97)
                c = CMD_NEWGEN;
            else if (clears_left > 0)
            begin
                c = CMD_CLEAR;
                clears_left--;
            end
            else
                c = CMD_PROBE;
            mask = (32'd1 << shadow_log2) - 32'd1;
            if (shadow_log2 == INDEX_BITS_DEF && $urandom_range(0, 4) != 0)
                idx = idx_pool[$urandom_range(0, 11)];
            else
                idx = $urandom & mask;
            if ($urandom_range(0, 9) < 8)
                key = key_pool[$urandom_range(0, 7)];
            else
                key = $urandom;
            push_word(c, {key, ($urandom & ~mask) | idx}, 16'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), 2'($urandom));
        end
    endfunction

    // Wait until every word is taken, every reply is back and the table is idle.
    task automatic wait_quiet();
        while (command_word_q.size() != 0 || start || table_reply_q.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    // Register write with a setup and an access phase; the register takes it on the access cycle.
    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        table_config(addr, data);
        @(negedge clk);
    endtask

    // Sender: bursts of words with random gaps; the model sees each accepted word.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                table_reply_q.push_back(table_apply(cur_word));
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (command_word_q.size() != 0)
                begin
                    cur_word = command_word_q.pop_front();
                    command <= cur_word.command;
                    hash <= cur_word.hash;
                    score_in <= cur_word.score;
                    from_in <= cur_word.from_sq;
                    move_to <= cur_word.to_sq;
                    depth_in <= cur_word.depth;
                    flag_in <= cur_word.flag;
                    start <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Receiver: every done word is compared with the oldest predicted reply.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (table_reply_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result word with no command outstanding", $realtime);
            end
            else
            begin
                want = table_reply_q.pop_front();
                if (hit !== want.hit || score_out !== want.score
                    || from_out !== want.from_sq || to_out !== want.to_sq
                    || depth_out !== want.depth || flag_out !== want.flag
                    || gen_out !== want.gen || fill_permille !== want.fill)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: %s expected hit=%0d score=%0d from=%0d to=%0d depth=%0d flag=%0d gen=%0d fill=%0d",
                                 $realtime, want.cmd.name(), want.hit, want.score,
                                 want.from_sq, want.to_sq, want.depth, want.flag,
                                 want.gen, want.fill);
                        $display("%0t: %s actual   hit=%0d score=%0d from=%0d to=%0d depth=%0d flag=%0d gen=%0d fill=%0d",
                                 $realtime, want.cmd.name(), hit, score_out, from_out,
                                 to_out, depth_out, flag_out, gen_out, fill_permille);
                    end
                end
            end
        end
    end

    // Main sequence: directed words, a generation sweep, then random phases
    // over several table sizes.
    initial
    begin
        table_wipe();
        shadow_gen = '0;
        shadow_log2 = LOG2_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extremes, the replacement rule, key zero and the sampled-slot boundary.
        push_word(CMD_PROBE, 64'h0, 16'h0, 8'h0, 8'h0, 8'h0, 2'd0);
        push_word(CMD_STORE, 64'hFFFF_FFFF_0000_FFFF, 16'h8000, 8'hFF, 8'hFF, 8'hFF, 2'd3);
        push_word(CMD_PROBE, 64'hFFFF_FFFF_0000_FFFF, 16'h0, 8'h0, 8'h0, 8'h0, 2'd0);
        push_word(CMD_STORE, 64'hFFFF_FFFF_0000_FFFF, 16'h7FFF, 8'h01, 8'h02, 8'h00, 2'd1);
        push_word(CMD_PROBE, 64'hFFFF_FFFF_0000_FFFF, 16'h0, 8'h0, 8'h0, 8'h0, 2'd0);
        push_word(CMD_STORE, 64'h0000_0001_0000_0000, 16'h7FFF, 8'h00, 8'h00, 8'h00, 2'd0);
        push_word(CMD_PROBE, 64'h0000_0001_0000_0000, 16'h0, 8'h0, 8'h0, 8'h0, 2'd0);
        push_word(CMD_PROBE, 64'h0000_0002_0000_0000, 16'h0, 8'h0, 8'h0, 8'h0, 2'd0);
        push_word(CMD_STORE, 64'h0000_0001_0000_0000, 16'hFFFF, 8'd10, 8'd20, 8'd5, 2'd2);
        push_word(CMD_STORE, 64'h0000_0001_0000_0000, 16'h1111, 8'd11, 8'd21, 8'd5, 2'd1);
        push_word(CMD_NEWGEN, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 2'd3);
        push_word(CMD_STORE, 64'h0000_0001_0000_0000, 16'h0123, 8'd3, 8'd4, 8'd1, 2'd1);
        push_word(CMD_PROBE, 64'h0000_0001_0000_0000, 16'h0, 8'h0, 8'h0, 8'h0, 2'd0);
        push_word(CMD_STORE, 64'h0, 16'h5555, 8'd7, 8'd7, 8'd7, 2'd3);
        push_word(CMD_PROBE, 64'h0, 16'h0, 8'h0, 8'h0, 8'h0, 2'd0);
        push_word(CMD_STORE, 64'hA5A5_5A5A_FFFF_03E7, 16'h2222, 8'd9, 8'd8, 8'd3, 2'd0);
        push_word(CMD_STORE, 64'h5A5A_A5A5_0000_03E8, 16'h3333, 8'd6, 8'd5, 8'd4, 2'd2);
        push_word(CMD_PROBE, 64'h5A5A_A5A5_0000_03E8, 16'h0, 8'h0, 8'h0, 8'h0, 2'd0);
        push_word(CMD_CLEAR, 64'h0, 16'h0, 8'h0, 8'h0, 8'h0, 2'd0);
        push_word(CMD_PROBE, 64'hFFFF_FFFF_0000_FFFF, 16'h0, 8'h0, 8'h0, 8'h0, 2'd0);
        push_word(CMD_STORE, 64'h8000_0000_FFFF_0003, 16'hC000, 8'h80, 8'h01, 8'h80, 2'd2);
        push_word(CMD_PROBE, 64'h8000_0000_FFFF_0003, 16'h0, 8'h0, 8'h0, 8'h0, 2'd0);

        // Walk the generation through a full wrap, checking the stamp now and then.
        for (int i = 0; i < 256; i++)
        begin
            if (i % 64 == 0)
            begin
                push_word(CMD_STORE, 64'h1234_5678_0000_1092, 16'($urandom), 8'($urandom),
                          8'($urandom), 8'(i), 2'($urandom));
                push_word(CMD_PROBE, 64'h1234_5678_0000_1092, 16'h0, 8'h0, 8'h0,
                          8'h0, 2'd0);
            end
            push_word(CMD_NEWGEN, {$urandom, $urandom}, 16'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), 2'($urandom));
        end

        refill_pools();
        push_random(60);
        wait_quiet();

        // Each size change clears the table, then random traffic on the new size.
        foreach (log2_plan[p])
        begin
            apb_write(TL2_ADDR, ($urandom & ~32'h1F) | log2_plan[p]);
            refill_pools();
            push_random(50);
            wait_quiet();
            if (log2_plan[p] == 9)
            begin
                // A write to an unmapped address must leave size and contents alone.
                apb_write(SPARE_ADDR, $urandom);
                push_random(50);
                wait_quiet();
            end
        end

        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && table_reply_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #(20_000_000);
        $display("tb_top failed");
        $finish;
    end

endmodule
